// ===== hw/rtl/wfa_pkg.sv =====
`timescale 1ns / 1ps

package wfa_pkg;

   // Configuration port
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // Register indexes (paddr[5:3])
   localparam logic [2:0] REG_WINDOW_TYPE   = 3'd0;
   localparam logic [2:0] REG_Y_BOUNDS      = 3'd1;
   localparam logic [2:0] REG_Z_BOUNDS      = 3'd2;
   localparam logic [2:0] REG_CIRCLE_CENTER = 3'd3;
   localparam logic [2:0] REG_CIRCLE_RADIUS = 3'd4;
   localparam logic [2:0] REG_LAMBDA_BOUNDS = 3'd5;
   localparam logic [2:0] REG_REF_WL_INV    = 3'd6;

   // Window selection codes; the unused codes mean no window
   localparam logic [1:0] WIN_CIRCLE = 2'd1;
   localparam logic [1:0] WIN_RECT   = 2'd2;

   // 1/1.798 in Q8.24
   localparam logic [31:0] REF_WL_INV_RESET = 32'd9331043;

   // x / 100 for 16-bit x: (x * 5242) >> 19 is exact or one low
   localparam logic [31:0] DIV100_RECIP = 32'd5242;
   localparam int          DIV100_SHIFT = 19;
   localparam logic [31:0] HUNDRED      = 32'd100;
   localparam int          COL_W        = 10;

   localparam int TERM_W = 57;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  window_type;
      logic [63:0] y_bounds;
      logic [63:0] z_bounds;
      logic [63:0] circle_center;
      logic [31:0] circle_radius;
      logic [63:0] lambda_bounds;
      logic [31:0] ref_wavelength_inverse;
   } cfg_type;

   typedef struct packed {
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] wavelength;
      logic [31:0] probability;
      logic [15:0] color;
      logic        end_of_block;
   } item_type;

   // Classified event passed from front to back
   typedef struct packed {
      logic        take;
      logic [31:0] wavelength;
      logic [31:0] probability;
      logic [15:0] color;
   } qent_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_DIFF,
      F_SQ_Y,
      F_SQ_Z,
      F_SQ_R,
      F_DECIDE,
      F_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_PW,
      B_HI,
      B_LO,
      B_TERM,
      B_SQ,
      B_Q100,
      B_COL,
      B_WC,
      B_ACC
   } back_state_type;

endpackage

// ===== hw/rtl/wfa_csr.sv =====
`timescale 1ns / 1ps

module wfa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wfa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wfa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wfa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output wfa_pkg::cfg_type                  cfg
);

   wfa_pkg::cfg_type cfg_ff;
   logic             wr_en;
   logic [2:0]       reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[5:3];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_type            <= 2'd0;
         cfg_ff.y_bounds               <= '0;
         cfg_ff.z_bounds               <= '0;
         cfg_ff.circle_center          <= '0;
         cfg_ff.circle_radius          <= '0;
         cfg_ff.lambda_bounds          <= '0;
         cfg_ff.ref_wavelength_inverse <= wfa_pkg::REF_WL_INV_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            wfa_pkg::REG_WINDOW_TYPE:   cfg_ff.window_type   <= csr_pwdata[1:0];
            wfa_pkg::REG_Y_BOUNDS:      cfg_ff.y_bounds      <= csr_pwdata;
            wfa_pkg::REG_Z_BOUNDS:      cfg_ff.z_bounds      <= csr_pwdata;
            wfa_pkg::REG_CIRCLE_CENTER: cfg_ff.circle_center <= csr_pwdata;
            wfa_pkg::REG_CIRCLE_RADIUS: cfg_ff.circle_radius <= csr_pwdata[31:0];
            wfa_pkg::REG_LAMBDA_BOUNDS: cfg_ff.lambda_bounds <= csr_pwdata;
            wfa_pkg::REG_REF_WL_INV:    cfg_ff.ref_wavelength_inverse <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         wfa_pkg::REG_WINDOW_TYPE:   csr_prdata = {62'd0, cfg_ff.window_type};
         wfa_pkg::REG_Y_BOUNDS:      csr_prdata = cfg_ff.y_bounds;
         wfa_pkg::REG_Z_BOUNDS:      csr_prdata = cfg_ff.z_bounds;
         wfa_pkg::REG_CIRCLE_CENTER: csr_prdata = cfg_ff.circle_center;
         wfa_pkg::REG_CIRCLE_RADIUS: csr_prdata = {32'd0, cfg_ff.circle_radius};
         wfa_pkg::REG_LAMBDA_BOUNDS: csr_prdata = cfg_ff.lambda_bounds;
         wfa_pkg::REG_REF_WL_INV:    csr_prdata = {32'd0, cfg_ff.ref_wavelength_inverse};
         default:                    csr_prdata = '0;
      endcase
   end

endmodule

// ===== hw/rtl/wfa_front.sv =====
`timescale 1ns / 1ps

module wfa_front (
   input  logic                clock,
   input  logic                reset,
   input  wfa_pkg::cfg_type    cfg,
   input  logic                in_valid,
   output logic                in_ready,
   input  wfa_pkg::item_type   in_item,
   output logic                push_valid,
   input  logic                push_ready,
   output wfa_pkg::qent_type   push_entry
);

   wfa_pkg::front_state_type state_ff, state_in;

   logic [31:0] y_ff, z_ff, wl_ff, p_ff;
   logic [15:0] color_ff;
   logic        eob_ff;
   logic [31:0] dy_ff, dz_ff;
   logic [63:0] prod_ff, sqy_ff, sqz_ff;
   logic        take_ff;

   logic [31:0] mul_a, mul_b;
   logic [32:0] diff_y, diff_z;
   logic [64:0] dist_sq;
   logic        circ_out, rect_out, lam_on, lam_out, win_out;
   logic [31:0] lmin, lmax;

   always_comb begin
      state_in   = state_ff;
      in_ready   = 1'b0;
      push_valid = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         wfa_pkg::F_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) state_in = wfa_pkg::F_DIFF;
         end
         wfa_pkg::F_DIFF: state_in = wfa_pkg::F_SQ_Y;
         wfa_pkg::F_SQ_Y: begin
            mul_a    = dy_ff;
            mul_b    = dy_ff;
            state_in = wfa_pkg::F_SQ_Z;
         end
         wfa_pkg::F_SQ_Z: begin
            mul_a    = dz_ff;
            mul_b    = dz_ff;
            state_in = wfa_pkg::F_SQ_R;
         end
         wfa_pkg::F_SQ_R: begin
            mul_a    = cfg.circle_radius;
            mul_b    = cfg.circle_radius;
            state_in = wfa_pkg::F_DECIDE;
         end
         wfa_pkg::F_DECIDE: state_in = wfa_pkg::F_PUSH;
         wfa_pkg::F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) state_in = wfa_pkg::F_IDLE;
         end
         default: state_in = wfa_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= wfa_pkg::F_IDLE;
      else       state_ff <= state_in;
   end

   // Signed distance to circle center, 33 bits before abs
   assign diff_y = {y_ff[31], y_ff} - {cfg.circle_center[31], cfg.circle_center[31:0]};
   assign diff_z = {z_ff[31], z_ff} - {cfg.circle_center[63], cfg.circle_center[63:32]};

   // prod_ff holds r^2 during DECIDE
   assign dist_sq  = {1'b0, sqy_ff} + {1'b0, sqz_ff};
   assign circ_out = dist_sq > {1'b0, prod_ff};
   assign rect_out = ($signed(y_ff) < $signed(cfg.y_bounds[31:0]))  ||
                     ($signed(y_ff) > $signed(cfg.y_bounds[63:32])) ||
                     ($signed(z_ff) < $signed(cfg.z_bounds[31:0]))  ||
                     ($signed(z_ff) > $signed(cfg.z_bounds[63:32]));
   assign lmin    = cfg.lambda_bounds[31:0];
   assign lmax    = cfg.lambda_bounds[63:32];
   assign lam_on  = (lmin != '0) && (lmax != '0);
   assign lam_out = lam_on && ((wl_ff < lmin) || (wl_ff > lmax));

   always_comb begin
      case (cfg.window_type)
         wfa_pkg::WIN_CIRCLE: win_out = circ_out;
         wfa_pkg::WIN_RECT:   win_out = rect_out;
         default:             win_out = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == wfa_pkg::F_IDLE && in_valid) begin
         y_ff     <= in_item.pos_y;
         z_ff     <= in_item.pos_z;
         wl_ff    <= in_item.wavelength;
         p_ff     <= in_item.probability;
         color_ff <= in_item.color;
         eob_ff   <= in_item.end_of_block;
      end
      if (state_ff == wfa_pkg::F_DIFF) begin
         dy_ff <= diff_y[32] ? 32'(-diff_y) : diff_y[31:0];
         dz_ff <= diff_z[32] ? 32'(-diff_z) : diff_z[31:0];
      end
      prod_ff <= mul_a * mul_b;
      if (state_ff == wfa_pkg::F_SQ_Z) sqy_ff <= prod_ff;
      if (state_ff == wfa_pkg::F_SQ_R) sqz_ff <= prod_ff;
      if (state_ff == wfa_pkg::F_DECIDE) take_ff <= !eob_ff && !win_out && !lam_out;
   end

   assign push_entry.take        = take_ff;
   assign push_entry.wavelength  = wl_ff;
   assign push_entry.probability = p_ff;
   assign push_entry.color       = color_ff;

endmodule

// ===== hw/rtl/wfa_queue.sv =====
`timescale 1ns / 1ps

module wfa_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  wfa_pkg::qent_type   push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output wfa_pkg::qent_type   pop_entry
);

   localparam int PTR_W = $clog2(wfa_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(wfa_pkg::QUEUE_DEPTH + 1);

   wfa_pkg::qent_type entry_ff [wfa_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(wfa_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(wfa_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(wfa_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (!do_push && do_pop) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== hw/rtl/wfa_back.sv =====
`timescale 1ns / 1ps

module wfa_back (
   input  logic                clock,
   input  logic                reset,
   input  wfa_pkg::cfg_type    cfg,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  wfa_pkg::qent_type   pop_entry,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_counted,
   output logic [63:0]         rsp_intensity_sum,
   output logic [63:0]         rsp_intensity_square_sum,
   output logic [31:0]         rsp_event_count,
   output logic [47:0]         rsp_color_sum,
   output logic [63:0]         rsp_weighted_color_sum
);

   wfa_pkg::back_state_type state_ff, state_in;

   logic                       take_ff;
   logic [31:0]                wl_ff, p_ff;
   logic [15:0]                color_ff;
   logic [63:0]                prod_ff, a_ff, hi_ff, sq_ff;
   logic [wfa_pkg::TERM_W-1:0] term_ff;
   logic [wfa_pkg::COL_W-1:0]  q_ff, col_ff;

   logic                       rsp_valid_ff, counted_ff;
   logic [63:0]                int_acc_ff, sq_acc_ff, wc_acc_ff;
   logic [31:0]                cnt_acc_ff;
   logic [47:0]                col_acc_ff;

   logic [31:0]                mul_a, mul_b;
   logic                       load;
   logic [64:0]                mid_sum;
   logic [wfa_pkg::TERM_W-1:0] term_in;
   logic [15:0]                rem16;
   logic [wfa_pkg::COL_W-1:0]  col_raw, col_in;
   logic [64:0]                int_sum, sq_sum, wc_sum;
   logic [48:0]                col_sum;

   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      load      = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         wfa_pkg::B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) state_in = pop_entry.take ? wfa_pkg::B_PW : wfa_pkg::B_ACC;
         end
         wfa_pkg::B_PW: begin
            mul_a    = p_ff;
            mul_b    = wl_ff;
            state_in = wfa_pkg::B_HI;
         end
         wfa_pkg::B_HI: begin
            mul_a    = prod_ff[63:32];
            mul_b    = cfg.ref_wavelength_inverse;
            state_in = wfa_pkg::B_LO;
         end
         wfa_pkg::B_LO: begin
            mul_a    = a_ff[31:0];
            mul_b    = cfg.ref_wavelength_inverse;
            state_in = wfa_pkg::B_TERM;
         end
         wfa_pkg::B_TERM: begin
            mul_a    = {16'd0, color_ff};
            mul_b    = wfa_pkg::DIV100_RECIP;
            state_in = wfa_pkg::B_SQ;
         end
         wfa_pkg::B_SQ: begin
            mul_a    = term_ff[31:0];
            mul_b    = term_ff[31:0];
            state_in = wfa_pkg::B_Q100;
         end
         wfa_pkg::B_Q100: begin
            mul_a    = {{(32 - wfa_pkg::COL_W){1'b0}}, q_ff};
            mul_b    = wfa_pkg::HUNDRED;
            state_in = wfa_pkg::B_COL;
         end
         wfa_pkg::B_COL: state_in = wfa_pkg::B_WC;
         wfa_pkg::B_WC: begin
            mul_a    = {{(32 - wfa_pkg::COL_W){1'b0}}, col_ff};
            mul_b    = p_ff;
            state_in = wfa_pkg::B_ACC;
         end
         wfa_pkg::B_ACC: begin
            // result register free now or freed at this edge
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = wfa_pkg::B_IDLE;
            end
         end
         default: state_in = wfa_pkg::B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= wfa_pkg::B_IDLE;
      else       state_ff <= state_in;
   end

   // term = (p*wl*inv) >> 40, built from two 32x32 partial products
   assign mid_sum = {1'b0, hi_ff} + {33'd0, prod_ff[63:32]};
   assign term_in = (cfg.ref_wavelength_inverse == '0) ?
                    {{(wfa_pkg::TERM_W - 32){1'b0}}, p_ff} : mid_sum[64:8];

   // color / 100 + color % 100 from the low estimate of the quotient; remainder below 200
   assign rem16   = color_ff - prod_ff[15:0];
   assign col_raw = q_ff + {2'd0, rem16[7:0]};
   assign col_in  = (rem16[7:0] >= 8'd100) ? col_raw - 10'd99 : col_raw;

   always_ff @(posedge clock) begin
      if (state_ff == wfa_pkg::B_IDLE && pop_valid) begin
         take_ff  <= pop_entry.take;
         wl_ff    <= pop_entry.wavelength;
         p_ff     <= pop_entry.probability;
         color_ff <= pop_entry.color;
      end
      if (state_ff != wfa_pkg::B_ACC) prod_ff <= mul_a * mul_b;
      if (state_ff == wfa_pkg::B_HI)   a_ff    <= prod_ff;
      if (state_ff == wfa_pkg::B_LO)   hi_ff   <= prod_ff;
      if (state_ff == wfa_pkg::B_TERM) term_ff <= term_in;
      if (state_ff == wfa_pkg::B_SQ)
         q_ff <= prod_ff[wfa_pkg::DIV100_SHIFT +: wfa_pkg::COL_W];
      if (state_ff == wfa_pkg::B_Q100)
         sq_ff <= (term_ff[wfa_pkg::TERM_W-1:32] != '0) ? wfa_pkg::MAX64 : prod_ff;
      if (state_ff == wfa_pkg::B_COL) col_ff <= col_in;
   end

   assign int_sum = {1'b0, int_acc_ff} + {{(65 - wfa_pkg::TERM_W){1'b0}}, term_ff};
   assign sq_sum  = {1'b0, sq_acc_ff} + {1'b0, sq_ff};
   assign wc_sum  = {1'b0, wc_acc_ff} + {23'd0, prod_ff[41:0]};
   assign col_sum = {1'b0, col_acc_ff} + {39'd0, col_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         int_acc_ff   <= '0;
         sq_acc_ff    <= '0;
         cnt_acc_ff   <= '0;
         col_acc_ff   <= '0;
         wc_acc_ff    <= '0;
      end else begin
         if (load)           rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (load && take_ff) begin
            int_acc_ff <= int_sum[64] ? wfa_pkg::MAX64 : int_sum[63:0];
            sq_acc_ff  <= sq_sum[64]  ? wfa_pkg::MAX64 : sq_sum[63:0];
            wc_acc_ff  <= wc_sum[64]  ? wfa_pkg::MAX64 : wc_sum[63:0];
            col_acc_ff <= col_sum[48] ? wfa_pkg::MAX48 : col_sum[47:0];
            if (cnt_acc_ff != wfa_pkg::MAX32) cnt_acc_ff <= cnt_acc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) counted_ff <= take_ff;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_counted              = counted_ff;
   assign rsp_intensity_sum        = int_acc_ff;
   assign rsp_intensity_square_sum = sq_acc_ff;
   assign rsp_event_count          = cnt_acc_ff;
   assign rsp_color_sum            = col_acc_ff;
   assign rsp_weighted_color_sum   = wc_acc_ff;

endmodule

// ===== hw/rtl/windowed_flux_accumulator_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// req_      in         tvalid / tready    tdata: pos_y, pos_z, wavelength, probability,
//                                         color; tlast: end_of_block
// rsp_      out        tvalid / tready    tdata: five running sums; tuser: counted
// csr_      in         APB, pready = 1    seven config registers, 64-bit, at 8*index
//
// Front takes one event at a time: capture, center distance, three squares on its
// one multiplier, window/band decision, hand-off to a 2-deep queue.
// Back runs a counted event through all its steps (one shared 32x32 multiplier, seven
// products in turn) and a rejected one straight to its final update; the back sets the
// pace for counted events, the front for rejected ones; each takes one event at a time.
// Reset (synchronous, active high) clears control and all sums, and returns the
// config registers to their defaults.
// A stalled rsp_ holds its transaction; the back waits only at its final update, the
// queue absorbs front/back skew, and req_tready drops while the front is busy.

module windowed_flux_accumulator_unit (
   input  logic                              clock,
   input  logic                              reset,
   // input events
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [143:0]                      req_tdata,  // pos_y, pos_z, wavelength,
                                                         // probability, color (LSB first)
   input  logic                              req_tlast,  // end_of_block
   // results
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [271:0]                      rsp_tdata,  // intensity_sum,
                                                         // intensity_square_sum,
                                                         // event_count, color_sum,
                                                         // weighted_color_sum (LSB first)
   output logic                              rsp_tuser,  // counted
   // configuration
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wfa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [wfa_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [wfa_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   wfa_pkg::cfg_type  cfg;
   wfa_pkg::item_type in_item;
   wfa_pkg::qent_type push_entry, pop_entry;
   logic              push_valid, push_ready, pop_valid, pop_ready;

   logic [63:0] intensity_sum, intensity_square_sum, weighted_color_sum;
   logic [31:0] event_count;
   logic [47:0] color_sum;

   assign in_item.pos_y        = req_tdata[31:0];
   assign in_item.pos_z        = req_tdata[63:32];
   assign in_item.wavelength   = req_tdata[95:64];
   assign in_item.probability  = req_tdata[127:96];
   assign in_item.color        = req_tdata[143:128];
   assign in_item.end_of_block = req_tlast;

   wfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // classify: window and wavelength band
   wfa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   wfa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // scale, square and accumulate; owns the result register
   wfa_back u_back (
      .clock                    (clock),
      .reset                    (reset),
      .cfg                      (cfg),
      .pop_valid                (pop_valid),
      .pop_ready                (pop_ready),
      .pop_entry                (pop_entry),
      .rsp_valid                (rsp_tvalid),
      .rsp_ready                (rsp_tready),
      .rsp_counted              (rsp_tuser),
      .rsp_intensity_sum        (intensity_sum),
      .rsp_intensity_square_sum (intensity_square_sum),
      .rsp_event_count          (event_count),
      .rsp_color_sum            (color_sum),
      .rsp_weighted_color_sum   (weighted_color_sum)
   );

   assign rsp_tdata = {weighted_color_sum, color_sum, event_count,
                       intensity_square_sum, intensity_sum};

endmodule

// ===== hw/rtl/wfa_checker.sv =====
`timescale 1ns / 1ps

module wfa_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [271:0] rsp_tdata,
   input logic         rsp_tuser
);

   logic [31:0] last_count_ff;
   logic        seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= 1'b0;
         last_count_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         seen_ff       <= 1'b1;
         last_count_ff <= rsp_tdata[159:128];
      end
   end

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && seen_ff && last_count_ff != 32'hFFFF_FFFF) |->
      (rsp_tdata[159:128] == last_count_ff + {31'd0, rsp_tuser}))
      else $error("event count does not follow counted flag");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[159:128] != 32'd0))
      else $error("counted event with zero count");

endmodule

bind windowed_flux_accumulator_unit wfa_checker u_wfa_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
